FILE: src/stl_pkg.sv
// Shared types, character codes, token kinds and the keyword table for the
// source token lexer. No dependencies; used by every module of the block.
package stl_pkg;

  // Longest token text that is counted; longer names are flagged.
  localparam int MAX_TOKEN_LEN = 64;

  // Number of leading name characters kept for keyword matching.
  localparam int KW_BUF = 6;
  localparam int KW_COUNT = 9;

  // Depth of the result queue and its pointer width.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Lexer modes.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_OP   = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_NAME = 2'd3
  } lex_mode_t;

  // Token kinds.
  localparam logic [4:0] KIND_GT    = 5'd10;
  localparam logic [4:0] KIND_INT   = 5'd18;
  localparam logic [4:0] KIND_IDENT = 5'd19;
  localparam logic [4:0] KIND_KW0   = 5'd20;
  localparam logic [4:0] KIND_ERROR = 5'd29;
  localparam logic [4:0] KIND_EOF   = 5'd30;

  // Error causes.
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_CHAR = 2'd1;
  localparam logic [1:0] CAUSE_INT  = 2'd2;
  localparam logic [1:0] CAUSE_NAME = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Operator selectors for the characters that may pair with '='.
  localparam logic [1:0] OP_GT   = 2'd0;
  localparam logic [1:0] OP_LT   = 2'd1;
  localparam logic [1:0] OP_EQ   = 2'd2;
  localparam logic [1:0] OP_BANG = 2'd3;

  // Keyword spellings, first character at index 0, zero padded.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_BUF] = '{
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},  // else
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},  // while
    '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00},  // print
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},  // void
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E},  // return
    '{8'h61, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00},  // and
    '{8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00}   // or
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd5, 3'd5, 3'd3, 3'd4, 3'd6, 3'd3, 3'd2
  };

  typedef logic [7:0] kw_buf_t [KW_BUF];

  // One result token.
  typedef struct packed {
    logic [4:0]  kind;
    logic [62:0] value;
    logic [23:0] line;
    logic [6:0]  length;
    logic [1:0]  cause;
    logic        last;
  } tok_t;

  // Results of one input item, compacted into the low slots.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } tok_pair_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // Build a token without line number or last flag.
  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [62:0] value,
                                  input logic [6:0] length, input logic [1:0] cause);
    tok_t t;
    t.kind   = kind;
    t.value  = value;
    t.line   = '0;
    t.length = length;
    t.cause  = cause;
    t.last   = 1'b0;
    return t;
  endfunction

  // Kind of a finished name: a keyword when length and stored characters match.
  function automatic logic [4:0] name_kind(input logic [6:0] len, input kw_buf_t chars);
    logic [4:0] kind;
    logic       same;
    logic       found;
    kind  = KIND_IDENT;
    found = 1'b0;
    for (int i = 0; i < KW_COUNT; i++) begin
      same = (len == {4'd0, KW_LEN[i]});
      for (int j = 0; j < KW_BUF; j++) begin
        if ((3'(j) < KW_LEN[i]) && (chars[j] != KW_TEXT[i][j])) begin
          same = 1'b0;
        end
      end
      if (same && !found) begin
        kind  = KIND_KW0 + 5'(i);
        found = 1'b1;
      end
    end
    return kind;
  endfunction

endpackage

FILE: src/stl_lex.sv
// Lexer state and the per-item step logic: one accepted character gives up to
// two tokens in the same cycle. Depends on stl_pkg.
module stl_lex
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic [7:0] src_byte,
  input  logic      end_flag,
  output tok_pair_t res
);

  lex_mode_t   mode_r, mode_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [62:0] num_val_r, num_val_nxt;
  logic        num_ovf_r, num_ovf_nxt;
  logic [6:0]  tok_len_r, tok_len_nxt;
  logic        too_long_r, too_long_nxt;
  logic [23:0] line_r, line_nxt;
  logic        eof_r, eof_nxt;
  logic [7:0]  kw_chars_r [KW_BUF];

  logic        kw_we;
  logic [2:0]  kw_idx;

  // Digit accumulation, shared by a number start and a number continuation.
  logic        num_cont;
  logic [62:0] base_val;
  logic        base_ovf;
  logic [6:0]  base_len;
  logic [66:0] base_ext;
  logic [66:0] acc;
  logic        acc_ovf;
  logic [62:0] acc_val;
  logic [6:0]  acc_len;
  logic        acc_err;

  assign num_cont = (mode_r == MODE_NUM);
  assign base_val = num_cont ? num_val_r : '0;
  assign base_ovf = num_cont ? num_ovf_r : 1'b0;
  assign base_len = num_cont ? tok_len_r : '0;
  assign base_ext = {4'd0, base_val};
  assign acc      = (base_ext << 3) + (base_ext << 1) + {63'd0, src_byte[3:0]};
  assign acc_ovf  = base_ovf | (|acc[66:63]);
  assign acc_val  = acc_ovf ? base_val : acc[62:0];
  assign acc_len  = base_len + 7'd1;
  assign acc_err  = (acc_len >= 7'(MAX_TOKEN_LEN));

  // Tokens that a pending number, name or operator gives when it ends.
  tok_t num_tok;
  tok_t name_tok;
  tok_t op_single;
  tok_t op_pair;

  always_comb begin
    num_tok   = num_ovf_r ? mk_tok(KIND_ERROR, '0, '0, CAUSE_INT)
                          : mk_tok(KIND_INT, num_val_r, tok_len_r, CAUSE_NONE);
    name_tok  = too_long_r ? mk_tok(KIND_ERROR, '0, 7'(MAX_TOKEN_LEN), CAUSE_NAME)
                           : mk_tok(name_kind(tok_len_r, kw_chars_r), '0, tok_len_r,
                                    CAUSE_NONE);
    op_single = mk_tok(KIND_GT + {2'd0, op_r, 1'b0}, '0, 7'd1, CAUSE_NONE);
    op_pair   = mk_tok(KIND_GT + {2'd0, op_r, 1'b1}, '0, 7'd2, CAUSE_NONE);
  end

  // Step logic: token A ends what was pending, token B comes from this character.
  logic a_v, b_v, do_start;
  tok_t a_tok, b_tok;

  always_comb begin
    mode_nxt     = mode_r;
    op_nxt       = op_r;
    num_val_nxt  = num_val_r;
    num_ovf_nxt  = num_ovf_r;
    tok_len_nxt  = tok_len_r;
    too_long_nxt = too_long_r;
    line_nxt     = line_r;
    eof_nxt      = eof_r;
    kw_we        = 1'b0;
    kw_idx       = tok_len_r[2:0];
    a_v          = 1'b0;
    b_v          = 1'b0;
    a_tok        = mk_tok(KIND_EOF, '0, '0, CAUSE_NONE);
    b_tok        = mk_tok(KIND_EOF, '0, '0, CAUSE_NONE);
    do_start     = 1'b0;

    if (eof_r) begin
      b_v = 1'b1;
    end else if (end_flag) begin
      unique case (mode_r)
        MODE_OP: begin
          a_v   = 1'b1;
          a_tok = op_single;
        end
        MODE_NUM: begin
          a_v   = 1'b1;
          a_tok = num_tok;
        end
        MODE_NAME: begin
          a_v   = 1'b1;
          a_tok = name_tok;
        end
        default: begin
          a_v = 1'b0;
        end
      endcase
      mode_nxt = MODE_IDLE;
      eof_nxt  = 1'b1;
      b_v      = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_OP: begin
          mode_nxt = MODE_IDLE;
          a_v      = 1'b1;
          if (src_byte == CH_EQ) begin
            a_tok = op_pair;
          end else begin
            a_tok    = op_single;
            do_start = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(src_byte)) begin
            num_val_nxt = acc_val;
            num_ovf_nxt = acc_ovf;
            tok_len_nxt = acc_len;
            if (acc_err) begin
              a_v      = 1'b1;
              a_tok    = mk_tok(KIND_ERROR, '0, '0, CAUSE_INT);
              mode_nxt = MODE_IDLE;
            end
          end else begin
            a_v      = 1'b1;
            a_tok    = num_tok;
            mode_nxt = MODE_IDLE;
            do_start = 1'b1;
          end
        end
        MODE_NAME: begin
          if (is_digit(src_byte) || is_alpha(src_byte)) begin
            if (tok_len_r < 7'(MAX_TOKEN_LEN)) begin
              kw_we       = (tok_len_r < 7'(KW_BUF));
              tok_len_nxt = tok_len_r + 7'd1;
            end else begin
              too_long_nxt = 1'b1;
            end
          end else begin
            a_v      = 1'b1;
            a_tok    = name_tok;
            mode_nxt = MODE_IDLE;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
    end

    // Start of a new token from the current character.
    if (do_start) begin
      priority if (src_byte == CH_LF) begin
        if (line_r != '1) begin
          line_nxt = line_r + 24'd1;
        end
      end else if ((src_byte == CH_SPACE) || (src_byte == CH_TAB) ||
                   (src_byte == CH_CR)) begin
        b_v = 1'b0;
      end else if (src_byte == CH_PLUS) begin
        b_v = 1'b1; b_tok = mk_tok(5'd0, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_MINUS) begin
        b_v = 1'b1; b_tok = mk_tok(5'd1, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_STAR) begin
        b_v = 1'b1; b_tok = mk_tok(5'd2, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_SLASH) begin
        b_v = 1'b1; b_tok = mk_tok(5'd3, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_LPAR) begin
        b_v = 1'b1; b_tok = mk_tok(5'd4, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_RPAR) begin
        b_v = 1'b1; b_tok = mk_tok(5'd5, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_LBRACE) begin
        b_v = 1'b1; b_tok = mk_tok(5'd6, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_RBRACE) begin
        b_v = 1'b1; b_tok = mk_tok(5'd7, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_COMMA) begin
        b_v = 1'b1; b_tok = mk_tok(5'd8, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_SEMI) begin
        b_v = 1'b1; b_tok = mk_tok(5'd9, '0, 7'd1, CAUSE_NONE);
      end else if (src_byte == CH_GT) begin
        mode_nxt = MODE_OP; op_nxt = OP_GT;
      end else if (src_byte == CH_LT) begin
        mode_nxt = MODE_OP; op_nxt = OP_LT;
      end else if (src_byte == CH_EQ) begin
        mode_nxt = MODE_OP; op_nxt = OP_EQ;
      end else if (src_byte == CH_BANG) begin
        mode_nxt = MODE_OP; op_nxt = OP_BANG;
      end else if (is_digit(src_byte)) begin
        num_val_nxt = acc_val;
        num_ovf_nxt = acc_ovf;
        tok_len_nxt = acc_len;
        if (acc_err) begin
          b_v      = 1'b1;
          b_tok    = mk_tok(KIND_ERROR, '0, '0, CAUSE_INT);
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_NUM;
        end
      end else if (is_alpha(src_byte)) begin
        mode_nxt     = MODE_NAME;
        too_long_nxt = 1'b0;
        kw_we        = 1'b1;
        kw_idx       = 3'd0;
        tok_len_nxt  = 7'd1;
      end else begin
        b_v   = 1'b1;
        b_tok = mk_tok(KIND_ERROR, '0, 7'd1, CAUSE_CHAR);
      end
    end
  end

  // Pack the results into the low slots and mark the final one.
  always_comb begin
    res.cnt = {1'b0, a_v} + {1'b0, b_v};
    res.t0  = a_v ? a_tok : b_tok;
    res.t1  = b_tok;
    res.t0.line = line_r;
    res.t1.line = line_r;
    res.t0.last = (res.cnt == 2'd1);
    res.t1.last = 1'b1;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      op_r       <= OP_GT;
      num_val_r  <= '0;
      num_ovf_r  <= 1'b0;
      tok_len_r  <= '0;
      too_long_r <= 1'b0;
      line_r     <= 24'd1;
      eof_r      <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      op_r       <= op_nxt;
      num_val_r  <= num_val_nxt;
      num_ovf_r  <= num_ovf_nxt;
      tok_len_r  <= tok_len_nxt;
      too_long_r <= too_long_nxt;
      line_r     <= line_nxt;
      eof_r      <= eof_nxt;
    end
  end

  // Leading characters of the current name, for keyword matching.
  always_ff @(posedge clk) begin
    if (step && kw_we) begin
      kw_chars_r[kw_idx] <= src_byte;
    end
  end

  // Once the end mark is taken, nothing stays pending.
  a_eof_idle: assert property (@(posedge clk) disable iff (!rst_n)
    eof_r |-> (mode_r == MODE_IDLE))
    else $error("lexer holds a pending token after end of input");

  // A digit run never reaches the length limit while still open.
  a_num_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_NUM) |-> (tok_len_r < 7'(MAX_TOKEN_LEN)))
    else $error("open number exceeds the length limit");

  // The line counter starts at one and never wraps.
  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter wrapped to zero");

endmodule

FILE: src/stl_tok_queue.sv
// Small result queue that takes up to two tokens a cycle and gives one.
// Depends on stl_pkg.
module stl_tok_queue
  import stl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tok_pair_t  push_data,
  input  logic       pop,
  output logic       not_empty,
  output logic       room_for_two,
  output tok_t       head
);

  localparam int CNT_W = QPTR_W + 1;

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        n_in;
  logic              do_pop;

  assign n_in         = push ? push_data.cnt : 2'd0;
  assign do_pop       = pop && (count_r != '0);
  assign not_empty    = (count_r != '0);
  assign room_for_two = (count_r <= CNT_W'(QDEPTH - 2));
  assign head         = mem_r[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt  = wptr_r + QPTR_W'(n_in);
    rptr_nxt  = rptr_r + QPTR_W'(do_pop);
    count_nxt = count_r + CNT_W'(n_in) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem_r[wptr_r] <= push_data.t0;
    end
    if (n_in == 2'd2) begin
      mem_r[wptr_r + QPTR_W'(1)] <= push_data.t1;
    end
  end

  // The queue is never written past its depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (n_in != 2'd0) |-> (count_r <= CNT_W'(QDEPTH) - CNT_W'(n_in)))
    else $error("result queue overflow");

  // The fill count tracks the pointers.
  a_count_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != CNT_W'(QDEPTH)) |-> (QPTR_W'(count_r) == QPTR_W'(wptr_r - rptr_r)))
    else $error("result queue count disagrees with pointers");

endmodule

FILE: src/source_token_lexer.sv
// Top level of the source token lexer: input register, step logic and
// result queue. Depends on stl_pkg, stl_lex and stl_tok_queue.
//
//   channel | direction | tdata                                  | tuser        | tlast
//   in_     | slave     | source_byte                            | end_of_input | -
//   out_    | master     | int_value, line_number, lexeme_length, | token_kind   | last_of_run
//           |           | error_cause                            |              |
//
// A character is taken in every cycle while the result queue has room for two
// tokens; its tokens pass the input register and the result queue before the output.
// The output gives one token per cycle while out_tready is high, so items that end
// one token and start another give two tokens and the queue absorbs the difference.
// Reset (rst_n low, synchronous) empties the input register and the queue and
// returns the lexer to line one with nothing pending.
// A stalled output holds its token; the input stalls when the queue lacks room for two.
module source_token_lexer
  import stl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [62:0] int_value, [86:63] line_number,
                                  // [93:87] lexeme_length, [95:94] error_cause
  output logic [4:0]  out_tuser,  // [4:0] token_kind
  output logic        out_tlast   // last_of_run
);

  logic       in_v_r, in_v_nxt;
  logic [7:0] byte_r;
  logic       end_r;
  logic       step;
  logic       room_for_two;
  tok_pair_t  res;
  tok_t       head;

  // Input register advances when its item moves into the lexer.
  assign step      = in_v_r && room_for_two;
  assign in_tready = !in_v_r || step;
  assign in_v_nxt  = (in_tvalid && in_tready) || (in_v_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      end_r  <= in_tuser;
    end
  end

  stl_lex u_lex (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .src_byte (byte_r),
    .end_flag (end_r),
    .res      (res)
  );

  stl_tok_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (step),
    .push_data    (res),
    .pop          (out_tready),
    .not_empty    (out_tvalid),
    .room_for_two (room_for_two),
    .head         (head)
  );

  // Result transaction fields.
  assign out_tdata = {head.cause, head.length, head.line, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  // An item in the input register moves on as soon as the queue has room.
  a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && room_for_two) |=> !in_v_r || $past(in_tvalid && in_tready))
    else $error("input register held an item with queue room");

  // An end-of-input transaction always produces at least its eof token.
  a_res_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (step && end_r) |-> (res.cnt != 2'd0))
    else $error("end of input gave no token");

  // Token kinds stay in their defined range.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= KIND_EOF))
    else $error("token kind out of range");

endmodule

FILE: dv/tb_source_token_lexer.sv
// Self-checking testbench for source_token_lexer: directed characters, then a random
// source text, all checked against a token predictor kept in this file.
// Depends on stl_pkg and the source_token_lexer RTL only.
module tb_source_token_lexer;
  import stl_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_WAIT = 18;
  localparam int RANDOM_ITEMS = 1100;
  localparam int PRINT_CAP = 40;
  localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [23:0] LINE_TOP = 24'hFF_FFFF;

  // Token kinds named by the directed table; the rest come from the package.
  localparam logic [4:0] KIND_PLUS = 5'd0;
  localparam logic [4:0] KIND_SEMI = 5'd9;
  localparam logic [4:0] KIND_GE   = 5'd11;
  localparam logic [4:0] KIND_LT   = 5'd12;
  localparam logic [4:0] KIND_EQ2  = 5'd15;
  localparam logic [4:0] KIND_BANG = 5'd16;

  // Single-character tokens; the index is the token kind.
  localparam logic [7:0] SINGLE_CH [10] = '{
    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR,
    CH_RPAR, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_SEMI
  };
  // Characters that may pair with '=', indexed by operator selector.
  localparam logic [7:0] REL_CH [4] = '{CH_GT, CH_LT, CH_EQ, CH_BANG};

  // One directed row; kind, length and cause are used only when typed is set.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    logic [4:0] kind;
    logic [6:0] len;
    logic [1:0] cause;
  } dir_row_t;

  localparam int DIR_COUNT = 24;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{CH_SEMI,  1'b0, 1'b1, KIND_SEMI,  7'd1, CAUSE_NONE},
    '{8'h00,    1'b0, 1'b1, KIND_ERROR, 7'd1, CAUSE_CHAR},
    '{8'hFF,    1'b0, 1'b1, KIND_ERROR, 7'd1, CAUSE_CHAR},
    '{CH_GT,    1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{CH_EQ,    1'b0, 1'b1, KIND_GE,    7'd2, CAUSE_NONE},
    '{CH_BANG,  1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{"a",      1'b0, 1'b1, KIND_BANG,  7'd1, CAUSE_NONE},
    '{"n",      1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{"d",      1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{CH_LF,    1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{"0",      1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{CH_LT,    1'b0, 1'b1, KIND_INT,   7'd1, CAUSE_NONE},
    '{CH_LT,    1'b0, 1'b1, KIND_LT,    7'd1, CAUSE_NONE},
    '{"9",      1'b0, 1'b1, KIND_LT,    7'd1, CAUSE_NONE},
    '{"9",      1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{CH_SPACE, 1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{"Z",      1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{"9",      1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{CH_TAB,   1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{CH_EQ,    1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{CH_EQ,    1'b0, 1'b1, KIND_EQ2,   7'd2, CAUSE_NONE},
    '{8'h80,    1'b0, 1'b1, KIND_ERROR, 7'd1, CAUSE_CHAR},
    '{CH_CR,    1'b0, 1'b0, KIND_GT,    7'd0, CAUSE_NONE},
    '{CH_PLUS,  1'b0, 1'b1, KIND_PLUS,  7'd1, CAUSE_NONE}
  };

  string keywords [9] = '{"if", "else", "while", "print", "int", "void", "return",
                          "and", "or"};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  // Predictor state.
  lex_mode_t   lx_mode;
  logic [1:0]  lx_op;
  logic [63:0] acc_value;
  logic        acc_ovf;
  int          run_len;
  logic        name_long;
  logic [7:0]  name_head [KW_BUF];
  logic [23:0] line_no;
  logic        eof_done;

  tok_t        step_toks [$];
  tok_t        pending_tokens [$];
  logic [7:0]  src_text [$];
  int          mismatches;
  int          tokens_seen;
  int          cycles;
  int          send_calm;
  int          sink_calm;

  source_token_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("token %0d %s: got %0h, expected %0h",
                                tokens_seen, name, got, want));
    end
  endtask

  // Wait length for one transaction; now and then a stretch with no waits at all.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(8, 48);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic void emit_tok(input logic [4:0] kind, input logic [62:0] value,
                                   input logic [6:0] len, input logic [1:0] cause);
    tok_t t;
    t.kind   = kind;
    t.value  = value;
    t.line   = line_no;
    t.length = len;
    t.cause  = cause;
    t.last   = 1'b0;
    step_toks.push_back(t);
  endfunction

  // Add one digit to the running number; a run that reaches MAX_TOKEN_LEN ends as an error.
  function automatic void take_digit(input logic [7:0] b);
    logic [63:0] d;
    d = 64'(b) - 64'("0");
    if (!acc_ovf) begin
      if (acc_value > (VALUE_MAX - d) / 10) begin
        acc_ovf = 1'b1;
      end else begin
        acc_value = acc_value * 10 + d;
      end
    end
    run_len++;
    if (run_len >= MAX_TOKEN_LEN) begin
      emit_tok(KIND_ERROR, '0, '0, CAUSE_INT);
      lx_mode = MODE_IDLE;
    end
  endfunction

  function automatic void flush_number();
    if (acc_ovf) begin
      emit_tok(KIND_ERROR, '0, '0, CAUSE_INT);
    end else begin
      emit_tok(KIND_INT, acc_value[62:0], 7'(run_len), CAUSE_NONE);
    end
    lx_mode = MODE_IDLE;
  endfunction

  // A finished name is a keyword when its length and leading characters match.
  function automatic void flush_word();
    logic [4:0] kind;
    logic       same;
    string      w;
    kind = KIND_IDENT;
    if (name_long) begin
      emit_tok(KIND_ERROR, '0, 7'(MAX_TOKEN_LEN), CAUSE_NAME);
    end else begin
      for (int i = 8; i >= 0; i--) begin
        w = keywords[i];
        same = (run_len == w.len());
        for (int j = 0; same && j < w.len(); j++) begin
          if (name_head[j] != 8'(w[j])) same = 1'b0;
        end
        if (same) kind = KIND_KW0 + 5'(i);
      end
      emit_tok(kind, '0, 7'(run_len), CAUSE_NONE);
    end
    lx_mode = MODE_IDLE;
  endfunction

  // Lex a character from the idle state.
  function automatic void start_char(input logic [7:0] b);
    if (b == CH_LF) begin
      if (line_no != LINE_TOP) line_no++;
      return;
    end
    if (b == CH_SPACE || b == CH_TAB || b == CH_CR) return;
    for (int i = 0; i < 10; i++) begin
      if (b == SINGLE_CH[i]) begin
        emit_tok(5'(i), '0, 7'd1, CAUSE_NONE);
        return;
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (b == REL_CH[i]) begin
        lx_mode = MODE_OP;
        lx_op = 2'(i);
        return;
      end
    end
    if (is_num(b)) begin
      lx_mode = MODE_NUM;
      acc_value = '0;
      acc_ovf = 1'b0;
      run_len = 0;
      take_digit(b);
    end else if (is_letter(b)) begin
      lx_mode = MODE_NAME;
      name_long = 1'b0;
      name_head[0] = b;
      run_len = 1;
    end else begin
      emit_tok(KIND_ERROR, '0, 7'd1, CAUSE_CHAR);
    end
  endfunction

  // Tokens caused by one input transaction, left in step_toks.
  function automatic void lex_step(input logic [7:0] b, input logic eoi);
    if (eof_done) begin
      emit_tok(KIND_EOF, '0, '0, CAUSE_NONE);
    end else if (eoi) begin
      case (lx_mode)
        MODE_OP:   emit_tok(KIND_GT + 5'({lx_op, 1'b0}), '0, 7'd1, CAUSE_NONE);
        MODE_NUM:  flush_number();
        MODE_NAME: flush_word();
        default: ;
      endcase
      lx_mode = MODE_IDLE;
      eof_done = 1'b1;
      emit_tok(KIND_EOF, '0, '0, CAUSE_NONE);
    end else if (lx_mode == MODE_OP) begin
      lx_mode = MODE_IDLE;
      if (b == CH_EQ) begin
        emit_tok(KIND_GT + 5'({lx_op, 1'b1}), '0, 7'd2, CAUSE_NONE);
      end else begin
        emit_tok(KIND_GT + 5'({lx_op, 1'b0}), '0, 7'd1, CAUSE_NONE);
        start_char(b);
      end
    end else if (lx_mode == MODE_NUM) begin
      if (is_num(b)) begin
        take_digit(b);
      end else begin
        flush_number();
        start_char(b);
      end
    end else if (lx_mode == MODE_NAME) begin
      if (is_num(b) || is_letter(b)) begin
        if (run_len < MAX_TOKEN_LEN) begin
          if (run_len < KW_BUF) name_head[run_len] = b;
          run_len++;
        end else begin
          name_long = 1'b1;
        end
      end else begin
        flush_word();
        start_char(b);
      end
    end else begin
      start_char(b);
    end
  endfunction

  // Record the expected tokens of an accepted transaction; a typed row replaces the
  // predicted fields with the values written in the table.
  task automatic accept_item(input logic [7:0] b, input logic eoi, input dir_row_t row);
    tok_t t;
    step_toks.delete();
    lex_step(b, eoi);
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
    if (row.typed) begin
      if (step_toks.size() == 1) begin
        t = step_toks.pop_back();
        t.kind   = row.kind;
        t.value  = '0;
        t.length = row.len;
        t.cause  = row.cause;
        step_toks.push_back(t);
      end else begin
        report_mismatch($sformatf("directed row %0h gives %0d tokens", b, step_toks.size()));
      end
    end
    foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
  endtask

  // Present one transaction after a random gap and hold it until it is taken.
  task automatic drive_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = pick_wait(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = b;
    in_tuser  = eoi;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 5) == 0) ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Random source text made mostly of well-formed tokens, with some noise bytes.
  task automatic build_text();
    int    pick;
    int    n;
    string w;
    while (src_text.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        src_text.push_back(SINGLE_CH[$urandom_range(0, 9)]);
      end else if (pick < 24) begin
        src_text.push_back(REL_CH[$urandom_range(0, 3)]);
        if ($urandom_range(0, 1) == 1) src_text.push_back(CH_EQ);
      end else if (pick < 48) begin
        // Numbers: mostly short, some at the edge of the value range or of the run length.
        case ($urandom_range(0, 19))
          0: begin
            w = "922337203685477580";
            for (int j = 0; j < w.len(); j++) src_text.push_back(8'(w[j]));
            src_text.push_back(8'("0" + $urandom_range(5, 9)));
            if ($urandom_range(0, 3) == 0) src_text.push_back(8'("0" + $urandom_range(0, 9)));
          end
          1: n = $urandom_range(60, 68);
          2: n = 20;
          default: n = $urandom_range(1, 12);
        endcase
        if (w.len() == 0) begin
          repeat (n) src_text.push_back(8'("0" + $urandom_range(0, 9)));
        end
        w = "";
      end else if (pick < 62) begin
        // Keywords, sometimes cut short or extended into plain names.
        w = keywords[$urandom_range(0, 8)];
        n = w.len();
        if ($urandom_range(0, 4) == 0) n--;
        for (int j = 0; j < n; j++) src_text.push_back(8'(w[j]));
        if ($urandom_range(0, 4) == 0) src_text.push_back(rand_alnum());
        w = "";
      end else if (pick < 84) begin
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 68) : $urandom_range(1, 10);
        src_text.push_back(rand_letter());
        repeat (n - 1) src_text.push_back(rand_alnum());
      end else if (pick < 90) begin
        src_text.push_back(8'($urandom_range(0, 255)));
      end else begin
        src_text.push_back(rand_blank());
      end
      if ($urandom_range(0, 9) < 6) src_text.push_back(rand_blank());
    end
  endtask

  // Cycle count and run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d tokens outstanding", pending_tokens.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Compare every output transaction with the oldest expected token.
  always @(posedge clk) begin : token_check
    tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("token kind %0d with nothing expected", out_tuser));
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind", 64'(out_tuser), 64'(want.kind));
        check_field("value", 64'(out_tdata[62:0]), 64'(want.value));
        check_field("line", 64'(out_tdata[86:63]), 64'(want.line));
        check_field("length", 64'(out_tdata[93:87]), 64'(want.length));
        check_field("cause", 64'(out_tdata[95:94]), 64'(want.cause));
        check_field("last", 64'(out_tlast), 64'(want.last));
      end
      tokens_seen++;
    end
  end

  // Output side: random stalls before each transaction.
  initial begin : token_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall = pick_wait(sink_calm);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Reset, directed table, random text, end of input, then drain and verdict.
  initial begin : stimulus
    dir_row_t plain;
    logic     eoi;
    plain = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    mismatches = 0;
    tokens_seen = 0;
    cycles = 0;
    send_calm = 0;
    sink_calm = 0;
    lx_mode = MODE_IDLE;
    lx_op = OP_GT;
    acc_value = '0;
    acc_ovf = 1'b0;
    run_len = 0;
    name_long = 1'b0;
    line_no = 24'd1;
    eof_done = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_COUNT; i++) begin
      drive_item(DIR_ROWS[i].ch, DIR_ROWS[i].eoi);
      accept_item(DIR_ROWS[i].ch, DIR_ROWS[i].eoi, DIR_ROWS[i]);
    end

    build_text();
    foreach (src_text[i]) begin
      drive_item(src_text[i], 1'b0);
      accept_item(src_text[i], 1'b0, plain);
    end

    // End of input flushes whatever is pending; later transactions give only eof.
    for (int i = 0; i < 4; i++) begin
      eoi = (i != 1);
      plain.ch = 8'($urandom_range(0, 255));
      drive_item(plain.ch, eoi);
      accept_item(plain.ch, eoi, plain);
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      report_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
